/* src/sstr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstr_pkg
// Types, geometry constants and lookup functions shared by the seven-segment
// timer rectangle renderer.
// ---------------------------------------------------------------------------
package sstr_pkg;

	// display command codes
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_FILL  = 1'b1;

	// op codes of an input word
	localparam logic OP_SHOW    = 1'b0;
	localparam logic OP_REPAINT = 1'b1;

	// digit geometry
	localparam int DIGIT_TOP = 4;
	localparam int DIGIT_W   = 26;
	localparam int DIGIT_H   = 56;
	localparam int BAR       = 5;
	localparam int VBAR_LEN  = 20;
	localparam int HBAR_LEN  = 16;
	localparam int MID_TOP   = DIGIT_TOP + DIGIT_H / 2 - BAR / 2;
	localparam int LOW_TOP   = MID_TOP + BAR;
	localparam int UPPER_TOP = DIGIT_TOP + BAR;
	localparam int RIGHT_OFF = DIGIT_W - BAR;

	localparam logic [6:0] TENS_LEFT   = 7'd14;
	localparam logic [6:0] ONES_LEFT   = 7'd44;
	localparam logic [6:0] TENTHS_LEFT = 7'd86;
	localparam logic [6:0] DOT_LEFT    = 7'd75;
	localparam logic [5:0] DOT_TOP     = 6'd52;
	localparam logic [6:0] DOT_SIDE    = 7'd7;

	// command slots of one repaint: clear, tens, ones, dot, tenths
	localparam logic [4:0] SLOT_CLEAR     = 5'd0;
	localparam logic [4:0] SLOT_TENS      = 5'd1;
	localparam logic [4:0] SLOT_ONES      = 5'd8;
	localparam logic [4:0] SLOT_DOT       = 5'd15;
	localparam logic [4:0] SLOT_TENTHS    = 5'd16;
	localparam logic [4:0] SLOT_FINAL     = 5'd22;

	// reciprocal constants for the dividers
	localparam logic [17:0] RECIP_100 = 18'd167773;  // 2^24 / 100, rounded up
	localparam logic [7:0]  RECIP_10  = 8'd205;      // 2^11 / 10, rounded up

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_DIGIT,
		ST_ONES,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [4:0] x_off;
		logic [5:0] y;
		logic [6:0] w;
		logic [5:0] h;
	} seg_rect_t;

	typedef struct packed {
		logic       command;
		logic [6:0] rect_x;
		logic [5:0] rect_y;
		logic [6:0] rect_width;
		logic [5:0] rect_height;
		logic       last;
	} draw_word_t;

	typedef struct packed {
		logic       capture;
		logic       set_repaint;
		logic       divide;
		logic       commit;
		logic       digits;
		logic       ones;
		logic       load_out;
		logic [4:0] slot;
	} dp_cmd_t;

	typedef struct packed {
		logic changed;
		logic lit;
		logic can_load;
	} dp_sts_t;

	// segment bits, A in bit 0 through G in bit 6
	function automatic logic [6:0] seg_mask(input logic [3:0] digit);
		logic [6:0] m;
		unique case (digit)
			4'd0:    m = 7'h3F;
			4'd1:    m = 7'h06;
			4'd2:    m = 7'h5B;
			4'd3:    m = 7'h4F;
			4'd4:    m = 7'h66;
			4'd5:    m = 7'h6D;
			4'd6:    m = 7'h7D;
			4'd7:    m = 7'h07;
			4'd8:    m = 7'h7F;
			4'd9:    m = 7'h6F;
			default: m = 7'h00;
		endcase
		return m;
	endfunction

	function automatic seg_rect_t seg_rect(input logic [2:0] seg);
		seg_rect_t r;
		unique case (seg)
			3'd0:    r = '{5'(BAR), 6'(DIGIT_TOP), 7'(HBAR_LEN), 6'(BAR)};
			3'd1:    r = '{5'(RIGHT_OFF), 6'(UPPER_TOP), 7'(BAR), 6'(VBAR_LEN)};
			3'd2:    r = '{5'(RIGHT_OFF), 6'(LOW_TOP), 7'(BAR), 6'(VBAR_LEN)};
			3'd3:    r = '{5'(BAR), 6'(DIGIT_TOP + DIGIT_H - BAR), 7'(HBAR_LEN), 6'(BAR)};
			3'd4:    r = '{5'd0, 6'(LOW_TOP), 7'(BAR), 6'(VBAR_LEN)};
			3'd5:    r = '{5'd0, 6'(UPPER_TOP), 7'(BAR), 6'(VBAR_LEN)};
			3'd6:    r = '{5'(BAR), 6'(MID_TOP), 7'(HBAR_LEN), 6'(BAR)};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* src/sstr_in_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstr_in_if
// Valid/ready channel carrying timer words into the renderer.
// ---------------------------------------------------------------------------
interface sstr_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] time_ms;

	modport source (output valid, output operation, output time_ms, input ready);
	modport sink (input valid, input operation, input time_ms, output ready);
endinterface

/* src/sstr_out_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstr_out_if
// Valid/ready channel carrying draw command words out of the renderer.
// ---------------------------------------------------------------------------
interface sstr_out_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [6:0] rect_x;
	logic [5:0] rect_y;
	logic [6:0] rect_width;
	logic [5:0] rect_height;
	logic       last;

	modport source (
		output valid, output command, output rect_x, output rect_y,
		output rect_width, output rect_height, output last, input ready
	);
	modport sink (
		input valid, input command, input rect_x, input rect_y,
		input rect_width, input rect_height, input last, output ready
	);
endinterface

/* src/seven_segment_timer_rect_renderer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// seven_segment_timer_rect_renderer
// Turns elapsed milliseconds into clear and fill-rectangle commands that draw
// a three-digit seven-segment seconds display with a decimal dot.
// ---------------------------------------------------------------------------
// usage
//   timer: one word per timer event. operation show converts time_ms to
//   deciseconds (saturating at MAX_DECISECONDS); operation repaint only arms
//   a repaint for the next show and produces nothing.
//   draw: up to 23 command words per repaint, a clear first, the final word
//   flagged with last. A show that leaves the value unchanged with no repaint
//   armed produces nothing.
// timing
//   timer.ready is high only while the sequencer is idle, so no new word is
//   taken until a repaint is through. A show steps through the conversion
//   states DIV, CHECK, DIGIT and ONES and then walks the command slots, one
//   slot per cycle while draw does not stall; a show with no change returns
//   to idle after CHECK, and a repaint word leaves the sequencer idle. Every
//   command word passes through the single output register.
// reset and stall
//   reset arms a repaint and clears the shown value. When draw stalls the
//   current word holds in the output register and the slot walk pauses on
//   the next lit slot until the word is taken.
// ---------------------------------------------------------------------------
module seven_segment_timer_rect_renderer #(
	parameter int MAX_DECISECONDS = 999
) (
	input logic        clk,
	input logic        arst_n,
	sstr_in_if.sink    timer,
	sstr_out_if.source draw
);

	sstr_pkg::dp_cmd_t    cmd;
	sstr_pkg::dp_sts_t    sts;
	sstr_pkg::draw_word_t word;

	sstr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.timer_valid (timer.valid),
		.timer_op    (timer.operation),
		.timer_ready (timer.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	sstr_datapath #(
		.MAX_DECISECONDS (MAX_DECISECONDS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.time_ms    (timer.time_ms),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (draw.ready),
		.out_valid  (draw.valid),
		.out_word   (word)
	);

	assign draw.command     = word.command;
	assign draw.rect_x      = word.rect_x;
	assign draw.rect_y      = word.rect_y;
	assign draw.rect_width  = word.rect_width;
	assign draw.rect_height = word.rect_height;
	assign draw.last        = word.last;

endmodule

/* src/sstr_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstr_ctrl
// Sequencer: takes a timer word, steps the datapath through the conversion
// and walks the command slots of a repaint.
// ---------------------------------------------------------------------------
module sstr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              timer_valid,
	input  logic              timer_op,
	output logic              timer_ready,
	input  sstr_pkg::dp_sts_t sts,
	output sstr_pkg::dp_cmd_t cmd
);

	sstr_pkg::state_t state_q;
	sstr_pkg::state_t state_nxt;
	logic [4:0]       slot_q;
	logic             accept;
	logic             slot_done;

	assign accept    = timer_valid && (state_q == sstr_pkg::ST_IDLE);
	// a slot is done when unlit, or when its word goes into the output register
	assign slot_done = !sts.lit || sts.can_load;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sstr_pkg::ST_IDLE: begin
				if (accept && timer_op == sstr_pkg::OP_SHOW) state_nxt = sstr_pkg::ST_DIV;
			end
			sstr_pkg::ST_DIV: state_nxt = sstr_pkg::ST_CHECK;
			sstr_pkg::ST_CHECK: begin
				state_nxt = sts.changed ? sstr_pkg::ST_DIGIT : sstr_pkg::ST_IDLE;
			end
			sstr_pkg::ST_DIGIT: state_nxt = sstr_pkg::ST_ONES;
			sstr_pkg::ST_ONES: state_nxt = sstr_pkg::ST_EMIT;
			sstr_pkg::ST_EMIT: begin
				if (slot_done && slot_q == sstr_pkg::SLOT_FINAL) state_nxt = sstr_pkg::ST_IDLE;
			end
			default: state_nxt = sstr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		timer_ready     = (state_q == sstr_pkg::ST_IDLE);
		cmd             = '0;
		cmd.slot        = slot_q;
		cmd.capture     = accept && timer_op == sstr_pkg::OP_SHOW;
		cmd.set_repaint = accept && timer_op == sstr_pkg::OP_REPAINT;
		cmd.divide      = (state_q == sstr_pkg::ST_DIV);
		cmd.commit      = (state_q == sstr_pkg::ST_CHECK) && sts.changed;
		cmd.digits      = (state_q == sstr_pkg::ST_DIGIT);
		cmd.ones        = (state_q == sstr_pkg::ST_ONES);
		cmd.load_out    = (state_q == sstr_pkg::ST_EMIT) && sts.lit && sts.can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sstr_pkg::ST_IDLE;
			slot_q  <= sstr_pkg::SLOT_CLEAR;
		end else begin
			state_q <= state_nxt;
			if (state_q != sstr_pkg::ST_EMIT) begin
				slot_q <= sstr_pkg::SLOT_CLEAR;
			end else if (slot_done) begin
				slot_q <= slot_q + 5'd1;
			end
		end
	end

endmodule

/* src/sstr_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstr_datapath
// Millisecond to decisecond conversion, digit split, repaint state and
// the draw word output register.
// ---------------------------------------------------------------------------
module sstr_datapath #(
	parameter int MAX_DECISECONDS = 999
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          time_ms,
	input  sstr_pkg::dp_cmd_t    cmd,
	output sstr_pkg::dp_sts_t    sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output sstr_pkg::draw_word_t out_word
);

	localparam logic [31:0] SAT_MS  = 32'(100 * (MAX_DECISECONDS + 1));
	localparam logic [9:0]  DS_MAX  = 10'(MAX_DECISECONDS);

	logic                 repaint_q;
	logic [9:0]           shown_q;
	logic [16:0]          ms_q;
	logic                 sat_q;
	logic [9:0]           ds_q;
	logic [6:0]           secs_q;
	logic [3:0]           tens_q;
	logic [3:0]           ones_q;
	logic [3:0]           tenths_q;
	logic                 full_q;
	sstr_pkg::draw_word_t word_q;

	logic [34:0]          ds_prod;
	logic [17:0]          secs_prod;
	logic [14:0]          tens_prod;
	logic [9:0]           secs_x10;
	logic [6:0]           tens_x10;

	logic [3:0]           digit;
	logic [2:0]           seg;
	logic [6:0]           x_left;
	logic [4:0]           seg_off;
	logic                 is_clear;
	logic                 is_dot;
	logic                 is_tenths;
	logic [6:0]           mask;
	logic [6:0]           tenths_mask;
	logic [7:0]           above;
	sstr_pkg::seg_rect_t  rect;
	sstr_pkg::draw_word_t word_nxt;

	assign ds_prod   = ms_q * sstr_pkg::RECIP_100;
	assign secs_prod = ds_q * sstr_pkg::RECIP_10;
	assign tens_prod = secs_q * sstr_pkg::RECIP_10;
	assign secs_x10  = {secs_q, 3'b000} + {2'b00, secs_q, 1'b0};
	assign tens_x10  = {tens_q, 3'b000} + {2'b00, tens_q, 1'b0};

	// slot decode: which digit and segment the current slot stands for
	always_comb begin
		digit     = 4'd0;
		seg       = 3'd0;
		x_left    = 7'd0;
		is_clear  = 1'b0;
		is_dot    = 1'b0;
		is_tenths = 1'b0;
		priority if (cmd.slot == sstr_pkg::SLOT_CLEAR) begin
			is_clear = 1'b1;
		end else if (cmd.slot < sstr_pkg::SLOT_ONES) begin
			digit  = tens_q;
			seg    = 3'(cmd.slot - sstr_pkg::SLOT_TENS);
			x_left = sstr_pkg::TENS_LEFT;
		end else if (cmd.slot < sstr_pkg::SLOT_DOT) begin
			digit  = ones_q;
			seg    = 3'(cmd.slot - sstr_pkg::SLOT_ONES);
			x_left = sstr_pkg::ONES_LEFT;
		end else if (cmd.slot == sstr_pkg::SLOT_DOT) begin
			is_dot = 1'b1;
		end else begin
			digit     = tenths_q;
			seg       = 3'(cmd.slot - sstr_pkg::SLOT_TENTHS);
			x_left    = sstr_pkg::TENTHS_LEFT;
			is_tenths = 1'b1;
		end
	end

	always_comb begin
		mask        = sstr_pkg::seg_mask(digit);
		tenths_mask = sstr_pkg::seg_mask(tenths_q);
		rect        = sstr_pkg::seg_rect(seg);
		seg_off     = rect.x_off;
		// segments of the tenths digit after this one
		above       = {1'b0, tenths_mask} >> ({1'b0, seg} + 4'd1);
		word_nxt    = '0;
		if (is_clear) begin
			word_nxt.command = sstr_pkg::CMD_CLEAR;
		end else if (is_dot) begin
			word_nxt.command     = sstr_pkg::CMD_FILL;
			word_nxt.rect_x      = sstr_pkg::DOT_LEFT;
			word_nxt.rect_y      = sstr_pkg::DOT_TOP;
			word_nxt.rect_width  = sstr_pkg::DOT_SIDE;
			word_nxt.rect_height = 6'(sstr_pkg::DOT_SIDE);
		end else begin
			word_nxt.command     = sstr_pkg::CMD_FILL;
			word_nxt.rect_x      = x_left + {2'b00, seg_off};
			word_nxt.rect_y      = rect.y;
			word_nxt.rect_width  = rect.w;
			word_nxt.rect_height = rect.h;
			word_nxt.last        = is_tenths && (above == 8'd0);
		end
	end

	assign sts.changed  = repaint_q || (ds_q != shown_q);
	assign sts.lit      = is_clear || is_dot || mask[seg];
	assign sts.can_load = !full_q || out_ready;

	assign out_valid = full_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repaint_q <= 1'b1;
			shown_q   <= 10'd0;
			full_q    <= 1'b0;
		end else begin
			if (cmd.set_repaint) begin
				repaint_q <= 1'b1;
			end else if (cmd.commit) begin
				repaint_q <= 1'b0;
			end
			if (cmd.commit) shown_q <= ds_q;
			if (cmd.load_out) begin
				full_q <= 1'b1;
			end else if (out_ready) begin
				full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ms_q  <= time_ms[16:0];
			sat_q <= (time_ms >= SAT_MS);
		end
		if (cmd.divide) ds_q <= sat_q ? DS_MAX : ds_prod[33:24];
		if (cmd.commit) secs_q <= secs_prod[17:11];
		if (cmd.digits) begin
			tenths_q <= 4'(ds_q - secs_x10);
			tens_q   <= tens_prod[14:11];
		end
		if (cmd.ones) ones_q <= 4'(secs_q - tens_x10);
		if (cmd.load_out) word_q <= word_nxt;
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the seven-segment timer rectangle renderer. Timer
// words go in over the valid/ready channel. A local predictor turns each
// accepted word into the draw words it should cause, and every accepted draw
// word is checked field by field against the oldest one still waiting. Both
// sides idle at random. One phase holds the draw side off for a long stretch.
// ---------------------------------------------------------------------------
module testbench;

	localparam int          CLK_HALF       = 2;
	localparam int          TB_MAX_DS      = 999;
	localparam int          IDLE_PCT       = 14;
	localparam int          LONG_HOLD      = 400;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          DRAIN_CYCLES   = 60;
	localparam int          RANDOM_WORDS   = 400;
	localparam int          PRINT_CAP      = 40;

	// lit bars per digit, A in bit 0 through G in bit 6
	localparam logic [6:0] DIGIT_BARS [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	typedef enum int {BAR_A, BAR_B, BAR_C, BAR_D, BAR_E, BAR_F, BAR_G} bar_id_t;

	logic clk;
	logic arst_n;

	sstr_in_if  timer_if ();
	sstr_out_if draw_if ();

	seven_segment_timer_rect_renderer #(
		.MAX_DECISECONDS(TB_MAX_DS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.timer (timer_if),
		.draw  (draw_if)
	);

	// predictor state
	logic       model_repaint;
	logic [9:0] model_shown;

	sstr_pkg::draw_word_t draw_expected [$];
	int         error_count;
	int         tx_idle_pct;
	int         rx_idle_pct;
	bit         hold_request;
	logic [31:0] last_ms;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("mismatch: %s", msg);
		error_count++;
	endtask

	function automatic sstr_pkg::draw_word_t make_word(input logic cmd, input logic [6:0] x,
			input logic [5:0] y, input logic [6:0] w, input logic [5:0] h,
			input logic closes);
		sstr_pkg::draw_word_t d;
		d.command     = cmd;
		d.rect_x      = x;
		d.rect_y      = y;
		d.rect_width  = w;
		d.rect_height = h;
		d.last        = closes;
		return d;
	endfunction

	function automatic sstr_pkg::draw_word_t bar_word(input logic [6:0] left, input int bar,
			input logic closes);
		sstr_pkg::draw_word_t d;
		case (bar)
			BAR_A:   d = make_word(sstr_pkg::CMD_FILL, left + 7'd5, 6'd4, 7'd16, 6'd5, closes);
			BAR_B:   d = make_word(sstr_pkg::CMD_FILL, left + 7'd21, 6'd9, 7'd5, 6'd20, closes);
			BAR_C:   d = make_word(sstr_pkg::CMD_FILL, left + 7'd21, 6'd35, 7'd5, 6'd20, closes);
			BAR_D:   d = make_word(sstr_pkg::CMD_FILL, left + 7'd5, 6'd55, 7'd16, 6'd5, closes);
			BAR_E:   d = make_word(sstr_pkg::CMD_FILL, left, 6'd35, 7'd5, 6'd20, closes);
			BAR_F:   d = make_word(sstr_pkg::CMD_FILL, left, 6'd9, 7'd5, 6'd20, closes);
			default: d = make_word(sstr_pkg::CMD_FILL, left + 7'd5, 6'd30, 7'd16, 6'd5, closes);
		endcase
		return d;
	endfunction

	// closes marks the digit whose highest lit bar ends the repaint
	task automatic predict_digit(input logic [6:0] left, input int digit, input logic closes);
		logic [6:0] bars;
		int         top_bar;
		bars    = DIGIT_BARS[digit];
		top_bar = 0;
		for (int b = 0; b < 7; b++)
			if (bars[b]) top_bar = b;
		for (int b = 0; b < 7; b++)
			if (bars[b])
				draw_expected.push_back(bar_word(left, b, closes && (b == top_bar)));
	endtask

	task automatic predict_timer_word(input logic op, input logic [31:0] ms);
		logic [31:0] ds_full;
		logic [9:0]  ds;
		int          secs;
		if (op == sstr_pkg::OP_REPAINT) begin
			model_repaint = 1'b1;
			return;
		end
		ds_full = ms / 32'd100;
		if (ds_full > TB_MAX_DS)
			ds_full = TB_MAX_DS;
		ds = ds_full[9:0];
		if (!model_repaint && ds == model_shown)
			return;
		model_repaint = 1'b0;
		model_shown   = ds;
		secs          = int'(ds) / 10;
		draw_expected.push_back(make_word(sstr_pkg::CMD_CLEAR, 7'd0, 6'd0, 7'd0, 6'd0, 1'b0));
		predict_digit(7'd14, (secs / 10) % 10, 1'b0);
		predict_digit(7'd44, secs % 10, 1'b0);
		draw_expected.push_back(make_word(sstr_pkg::CMD_FILL, 7'd75, 6'd52, 7'd7, 6'd7, 1'b0));
		predict_digit(7'd86, int'(ds) % 10, 1'b1);
	endtask

	// valid stays high from one word to the next unless the sender idles between them
	task automatic send_timer_word(input logic op, input logic [31:0] ms);
		if ($urandom_range(99) < tx_idle_pct) begin
			timer_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		timer_if.valid     <= 1'b1;
		timer_if.operation <= op;
		timer_if.time_ms   <= ms;
		do @(posedge clk); while (!timer_if.ready);
		predict_timer_word(op, ms);
		last_ms = ms;
	endtask

	task automatic check_draw_word();
		sstr_pkg::draw_word_t got;
		sstr_pkg::draw_word_t want;
		got = make_word(draw_if.command, draw_if.rect_x, draw_if.rect_y,
			draw_if.rect_width, draw_if.rect_height, draw_if.last);
		if (draw_expected.size() == 0) begin
			report_mismatch($sformatf("unexpected draw word cmd=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
				got.command, got.rect_x, got.rect_y, got.rect_width, got.rect_height,
				got.last));
			return;
		end
		want = draw_expected.pop_front();
		if (got.command !== want.command || got.rect_x !== want.rect_x ||
				got.rect_y !== want.rect_y || got.rect_width !== want.rect_width ||
				got.rect_height !== want.rect_height || got.last !== want.last)
			report_mismatch($sformatf(
				"got cmd=%0d x=%0d y=%0d w=%0d h=%0d last=%0d, want %0d %0d %0d %0d %0d %0d",
				got.command, got.rect_x, got.rect_y, got.rect_width, got.rect_height,
				got.last, want.command, want.rect_x, want.rect_y, want.rect_width,
				want.rect_height, want.last));
	endtask

	// draw side: check every accepted word, then pick ready for the next cycle
	initial begin
		int hold_left;
		hold_left     = 0;
		draw_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (draw_if.valid && draw_if.ready)
				check_draw_word();
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				draw_if.ready <= 1'b0;
			end else begin
				draw_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((timer_if.valid && timer_if.ready) || (draw_if.valid && draw_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", quiet_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic test_extremes();
		send_timer_word(sstr_pkg::OP_SHOW, 32'd0);           // first show repaints after reset
		send_timer_word(sstr_pkg::OP_SHOW, 32'd0);           // unchanged
		send_timer_word(sstr_pkg::OP_SHOW, 32'd99);          // still zero deciseconds
		send_timer_word(sstr_pkg::OP_SHOW, 32'd100);
		send_timer_word(sstr_pkg::OP_SHOW, 32'hFFFF_FFFF);   // saturates
		send_timer_word(sstr_pkg::OP_SHOW, 32'd99_999);      // exactly the top value
		send_timer_word(sstr_pkg::OP_SHOW, 32'd100_000);     // first saturating value
		send_timer_word(sstr_pkg::OP_REPAINT, 32'hFFFF_FFFF);
		send_timer_word(sstr_pkg::OP_SHOW, 32'hFFFF_FFFF);   // forced repaint of same value
		send_timer_word(sstr_pkg::OP_REPAINT, 32'd0);
		send_timer_word(sstr_pkg::OP_REPAINT, 32'h5555_5555);
		send_timer_word(sstr_pkg::OP_SHOW, 32'h1234_5678);
	endtask

	task automatic test_all_digits();
		for (int d = 0; d < 10; d++)
			send_timer_word(sstr_pkg::OP_SHOW, 32'(11_100 * d + $urandom_range(99)));
		send_timer_word(sstr_pkg::OP_SHOW, 32'd99_950);
	endtask

	task automatic test_random_traffic(input int count);
		int          pick;
		logic [31:0] ms;
		for (int i = 0; i < count; i++) begin
			// a stretch with no idling on either side
			if (i == count / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (i == count / 3 + 80) begin
				tx_idle_pct = IDLE_PCT;
				rx_idle_pct = IDLE_PCT;
			end
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_timer_word(sstr_pkg::OP_REPAINT, $urandom());
			end else begin
				if (pick < 25)
					ms = last_ms + $urandom_range(120);
				else if (pick < 40)
					ms = last_ms;
				else if (pick < 55)
					ms = $urandom();
				else if (pick < 65)
					ms = $urandom_range(101_000, 99_000);
				else
					ms = $urandom_range(99_999);
				send_timer_word(sstr_pkg::OP_SHOW, ms);
			end
		end
	endtask

	task automatic test_backpressure();
		tx_idle_pct  = 0;
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 0)
				send_timer_word(sstr_pkg::OP_REPAINT, $urandom());
			else
				send_timer_word(sstr_pkg::OP_SHOW, $urandom_range(99_999));
		end
		tx_idle_pct = IDLE_PCT;
	endtask

	initial begin
		arst_n             = 1'b0;
		timer_if.valid     = 1'b0;
		timer_if.operation = sstr_pkg::OP_SHOW;
		timer_if.time_ms   = 32'd0;
		model_repaint      = 1'b1;
		model_shown        = 10'd0;
		error_count        = 0;
		tx_idle_pct        = IDLE_PCT;
		rx_idle_pct        = IDLE_PCT;
		hold_request       = 1'b0;
		last_ms            = 32'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_all_digits();
		test_random_traffic(RANDOM_WORDS);
		test_backpressure();

		timer_if.valid <= 1'b0;
		while (draw_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (draw_expected.size() != 0)
			report_mismatch($sformatf("%0d draw words never arrived", draw_expected.size()));
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* seven_segment_timer_rect_renderer.f */
src/sstr_pkg.sv
src/sstr_in_if.sv
src/sstr_out_if.sv
src/sstr_ctrl.sv
src/sstr_datapath.sv
src/seven_segment_timer_rect_renderer.sv
dv/testbench.sv
